>>> hdl/gsec_pkg.sv
`timescale 1ns / 1ps
// Shared types, coefficient tables and table builders for the gas sensor compensation.
// No dependencies.
package gsec_pkg;

    localparam logic [3:0] MODEL_NONE  = 4'd0;
    localparam logic [3:0] MODEL_GROUP = 4'd1;
    localparam logic [3:0] MODEL_S2    = 4'd2;
    localparam logic [3:0] MODEL_S3    = 4'd3;
    localparam logic [3:0] MODEL_S4    = 4'd4;
    localparam logic [3:0] MODEL_S5    = 4'd5;
    localparam logic [3:0] MODEL_S6    = 4'd6;
    localparam logic [3:0] MODEL_S7    = 4'd7;
    localparam logic [3:0] MODEL_ALC   = 4'd8;
    localparam logic [3:0] MODEL_OZONE = 4'd9;
    localparam logic [3:0] MODEL_FIRST = MODEL_GROUP;
    localparam logic [3:0] MODEL_LAST  = MODEL_OZONE;

    localparam int LOG_BITS_MAX = 10;

    localparam logic signed [15:0] T_MIN  = -16'sd2560;
    localparam logic signed [15:0] T_MAX  = 16'sd12800;
    localparam logic signed [16:0] T_OFF1 = 17'sd6400;
    localparam logic signed [16:0] T_OFF2 = 17'sd3840;
    localparam logic [22:0]        T_RND1 = 23'd7;
    localparam logic [22:0]        T_RND2 = 23'd2;
    localparam logic [24:0]        T_RCP1 = 25'd8947849;
    localparam logic [24:0]        T_RCP2 = 25'd26843546;
    localparam logic [14:0]        H_MAX  = 15'd21760;

    typedef struct packed {
        logic        tmap2;
        logic [14:0] h_lo;
        logic [14:0] split;
    } t_model;

    typedef struct packed {
        logic [14:0]        lo;
        logic [14:0]        hi;
        logic signed [15:0] a0;
        logic signed [15:0] a1;
        logic signed [15:0] b0;
        logic signed [15:0] b1;
        logic [15:0]        div;
        logic [18:0]        recip;
        logic [15:0]        off;
    } t_seg;

    function automatic t_model f_model(input logic [3:0] m);
        t_model r;
        case (m)
            MODEL_OZONE: r = '{tmap2: 1'b1, h_lo: 15'd8448, split: 15'd15360};
            MODEL_ALC:   r = '{tmap2: 1'b1, h_lo: 15'd7680, split: 15'd21760};
            default:     r = '{tmap2: 1'b0, h_lo: 15'd7680, split: 15'd21760};
        endcase
        return r;
    endfunction

    // wide span 33..85 %RH
    function automatic t_seg f_wide(input int a0, input int a1, input int b0, input int b1);
        return '{lo: 15'd8448, hi: 15'd21760, a0: 16'(a0), a1: 16'(a1), b0: 16'(b0),
                 b1: 16'(b1), div: 16'd32500, recip: 19'd132152, off: 16'd16250};
    endfunction

    function automatic t_seg f_seg(input logic [3:0] m, input logic upper);
        t_seg r;
        case (m)
            MODEL_GROUP: r = f_wide(16867, 15291, -4263, -4220);
            MODEL_S2:    r = f_wide(12767, 11013, -2204, -2482);
            MODEL_S3:    r = f_wide(13645, 11315, -2977, -2874);
            MODEL_S4:    r = f_wide(13128, 11252, -2428, -2496);
            MODEL_S5:    r = f_wide(14296, 11733, -3238, -2842);
            MODEL_S6:    r = f_wide(11474, 10783, -1958, -1824);
            MODEL_S7:    r = f_wide(14292, 11735, -3206, -2801);
            MODEL_ALC:   r = f_wide(16671, 14112, -2467, -2257);
            MODEL_OZONE: begin
                if (upper) begin
                    r = '{lo: 15'd15360, hi: 15'd21760, a0: 16'sd15885, a1: 16'sd13842,
                          b0: -16'sd2271, b1: -16'sd2282, div: 16'd15625,
                          recip: 19'd274877, off: 16'd7812};
                end else begin
                    r = '{lo: 15'd7680, hi: 15'd15360, a0: 16'sd18760, a1: 16'sd15885,
                          b0: -16'sd2284, b1: -16'sd2271, div: 16'd18750,
                          recip: 19'd229064, off: 16'd9375};
                end
            end
            default:     r = f_wide(16867, 15291, -4263, -4220);
        endcase
        return r;
    endfunction

    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [16:0] f_log_entry(input int lbits, input int k);
        logic [63:0] x;
        logic [16:0] res;
        x = (64'd1 << 30) + (64'(k) << (30 - lbits));
        res = '0;
        for (int i = 1; i <= 16; i++) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                res = res | (17'd1 << (16 - i));
            end
        end
        if (k == (1 << lbits)) res = 17'd1 << 16;
        return res;
    endfunction

    function automatic logic [31:0] f_exp_entry(input int lbits, input int k);
        logic [63:0] root [LOG_BITS_MAX + 1];
        logic [63:0] v;
        root[0] = 64'd1 << 31;
        for (int i = 1; i <= LOG_BITS_MAX; i++) begin
            root[i] = (i <= lbits) ? f_isqrt(root[i - 1] << 30) : 64'd0;
        end
        v = 64'd1 << 30;
        for (int i = 1; i <= lbits; i++) begin
            if (((k >> (lbits - i)) & 1) != 0) v = (v * root[i]) >> 30;
        end
        if (k == (1 << lbits)) v = 64'd1 << 31;
        return v[31:0];
    endfunction

endpackage

>>> hdl/gsec_in_if.sv
`timescale 1ns / 1ps
// Input channel: one temperature/humidity reading per transaction.
// No dependencies.
interface gsec_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature;
    logic [14:0]        humidity;
    modport source (output valid, output temperature, output humidity, input ready);
    modport sink (input valid, input temperature, input humidity, output ready);
endinterface

>>> hdl/gsec_out_if.sv
`timescale 1ns / 1ps
// Output channel: one correction factor per transaction.
// No dependencies.
interface gsec_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] correction;
    modport source (output valid, output correction, input ready);
    modport sink (input valid, input correction, output ready);
endinterface

>>> hdl/gsec_log2.sv
`timescale 1ns / 1ps
// log2 of a Q16 value in [1, 16): leading one plus interpolated table, Q16 result.
// Depends on gsec_pkg.
module gsec_log2 import gsec_pkg::*; #(
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic [19:0] i_t,
    output logic [17:0] o_lg
);
    localparam int N  = 1 << LOG_TABLE_BITS;
    localparam int RW = 30 - LOG_TABLE_BITS;

    logic [16:0]               w_tab [N + 1];
    logic [1:0]                w_ip;
    logic [33:0]               w_m;
    logic [LOG_TABLE_BITS-1:0] w_idx;
    logic [LOG_TABLE_BITS:0]   w_i0;
    logic [LOG_TABLE_BITS:0]   w_i1;
    logic [RW-1:0]             w_rem;
    logic [16:0]               w_lo;
    logic [16:0]               w_hi;
    logic [RW+16:0]            w_prod;

    for (genvar k = 0; k <= N; k++) begin : g_tab
        assign w_tab[k] = f_log_entry(LOG_TABLE_BITS, k);
    end

    always_comb begin
        w_ip   = i_t[19] ? 2'd3 : (i_t[18] ? 2'd2 : (i_t[17] ? 2'd1 : 2'd0));
        w_m    = {i_t, 14'b0} >> w_ip;
        w_idx  = w_m[29 -: LOG_TABLE_BITS];
        w_rem  = w_m[RW-1:0];
        w_i0   = {1'b0, w_idx};
        w_i1   = w_i0 + 1'b1;
        w_lo   = w_tab[w_i0];
        w_hi   = w_tab[w_i1];
        w_prod = (w_hi - w_lo) * w_rem;
        o_lg   = {w_ip, 16'b0} + 18'(w_lo) + 18'(w_prod >> RW);
    end
endmodule

>>> hdl/gsec_exp2.sv
`timescale 1ns / 1ps
// exp2 of a 16-bit fraction: interpolated table, Q30 result.
// Depends on gsec_pkg.
module gsec_exp2 import gsec_pkg::*; #(
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic [15:0] i_frac,
    output logic [31:0] o_ef
);
    localparam int N  = 1 << LOG_TABLE_BITS;
    localparam int RW = 16 - LOG_TABLE_BITS;

    logic [31:0]               w_tab [N + 1];
    logic [LOG_TABLE_BITS:0]   w_i0;
    logic [LOG_TABLE_BITS:0]   w_i1;
    logic [RW-1:0]             w_rem;
    logic [31:0]               w_lo;
    logic [31:0]               w_hi;
    logic [RW+31:0]            w_prod;

    for (genvar k = 0; k <= N; k++) begin : g_tab
        assign w_tab[k] = f_exp_entry(LOG_TABLE_BITS, k);
    end

    always_comb begin
        w_i0   = {1'b0, i_frac[15 -: LOG_TABLE_BITS]};
        w_i1   = w_i0 + 1'b1;
        w_rem  = i_frac[RW-1:0];
        w_lo   = w_tab[w_i0];
        w_hi   = w_tab[w_i1];
        w_prod = (w_hi - w_lo) * w_rem;
        o_ef   = w_lo + 32'(w_prod >> RW);
    end
endmodule

>>> hdl/gas_sensor_env_compensation.sv
`timescale 1ns / 1ps
// Gas sensor temperature/humidity compensation, top level.
// Depends on gsec_pkg, gsec_in_if, gsec_out_if, gsec_log2, gsec_exp2.
//
// Takes one reading per transaction and returns the correction a*t^b as unsigned
// Q2.14 (saturating). Throughput is one transaction per clock unless the output
// stalls. There is one register stage per step: temperature scaling and humidity
// interpolation products, log2 and reciprocal divide, divide correction, b*log2
// product, exp2, a*exp2 product, final round/shift. A stall on the output is
// absorbed stage by stage, so bubbles are squeezed out. sensor_model is written
// through i_cfg_we and must only change while the pipeline is empty.
module gas_sensor_env_compensation import gsec_pkg::*; #(
    parameter int OUT_FRAC_BITS  = 14,
    parameter int LOG_TABLE_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    gsec_in_if.sink     i_in,
    gsec_out_if.source  o_out
);
    localparam int          SH_BASE  = 46 - OUT_FRAC_BITS;
    localparam logic [15:0] UNIT_OUT = (OUT_FRAC_BITS >= 16) ? 16'hFFFF
                                                             : 16'(1 << OUT_FRAC_BITS);

    logic [3:0] r_sensor_model;
    logic [6:0] r_vld;
    logic [6:0] w_en;
    logic       w_known;

    logic [19:0]        r0_t;
    logic signed [31:0] r0_num_a, r0_num_b;
    logic               r0_upper, r0_known;

    logic [17:0] r1_lg;
    logic [18:0] r1_q_a, r1_q_b;
    logic [31:0] r1_v_a, r1_v_b;
    logic        r1_neg_a, r1_neg_b, r1_upper, r1_known;

    logic [17:0]        r2_lg;
    logic signed [19:0] r2_a, r2_b;
    logic               r2_known;

    logic signed [39:0] r3_py;
    logic signed [19:0] r3_a;
    logic               r3_known;

    logic [31:0]        r4_ef;
    logic signed [3:0]  r4_ip;
    logic signed [19:0] r4_a;
    logic               r4_known;

    logic [50:0]       r5_prod;
    logic signed [3:0] r5_ip;
    logic              r5_nonpos, r5_known;

    logic [15:0] r6_corr;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_model <= MODEL_NONE;
        end else if (i_cfg_we) begin
            r_sensor_model <= i_cfg_wdata;
        end
    end

    assign w_known = (r_sensor_model >= MODEL_FIRST) && (r_sensor_model <= MODEL_LAST);

    always_comb begin
        w_en[6] = !r_vld[6] || o_out.ready;
        for (int k = 5; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k + 1];
        end
    end

    assign i_in.ready       = w_en[0];
    assign o_out.valid      = r_vld[6];
    assign o_out.correction = r6_corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_in.valid;
            for (int k = 1; k < 7; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k - 1];
            end
        end
    end

    // stage 0: clamps, temperature map product, interpolation numerators
    t_model             w_m;
    t_seg               w_s0;
    logic signed [15:0] w_tc;
    logic signed [16:0] w_tx;
    logic [22:0]        w_vt;
    logic [47:0]        w_pt;
    logic [14:0]        w_h;
    logic               w_upper;
    logic signed [16:0] w_dhi, w_dlo;
    logic signed [33:0] w_na, w_nb;

    always_comb begin
        w_m = f_model(r_sensor_model);
        if (i_in.temperature < T_MIN) begin
            w_tc = T_MIN;
        end else if (i_in.temperature > T_MAX) begin
            w_tc = T_MAX;
        end else begin
            w_tc = i_in.temperature;
        end
        w_tx = 17'(w_tc) + (w_m.tmap2 ? T_OFF2 : T_OFF1);
        w_vt = {w_tx[14:0], 8'b0} + (w_m.tmap2 ? T_RND2 : T_RND1);
        w_pt = w_vt * (w_m.tmap2 ? T_RCP2 : T_RCP1);
        if (i_in.humidity < w_m.h_lo) begin
            w_h = w_m.h_lo;
        end else if (i_in.humidity > H_MAX) begin
            w_h = H_MAX;
        end else begin
            w_h = i_in.humidity;
        end
        w_upper = w_h > w_m.split;
        w_s0    = f_seg(r_sensor_model, w_upper);
        w_dhi   = $signed({2'b0, w_s0.hi}) - $signed({2'b0, w_h});
        w_dlo   = $signed({2'b0, w_h}) - $signed({2'b0, w_s0.lo});
        w_na    = w_s0.a0 * w_dhi + w_s0.a1 * w_dlo;
        w_nb    = w_s0.b0 * w_dhi + w_s0.b1 * w_dlo;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_t     <= w_pt[46:27];
            r0_num_a <= w_na[31:0];
            r0_num_b <= w_nb[31:0];
            r0_upper <= w_upper;
            r0_known <= w_known;
        end
    end

    // stage 1: log2, reciprocal products for a and b
    t_seg        w_s1;
    logic [17:0] w_lg;
    logic [31:0] w_mag_a, w_mag_b, w_v_a, w_v_b;
    logic [50:0] w_pa, w_pb;

    gsec_log2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log2 (
        .i_t  (r0_t),
        .o_lg (w_lg)
    );

    always_comb begin
        w_s1    = f_seg(r_sensor_model, r0_upper);
        w_mag_a = r0_num_a[31] ? 32'(-r0_num_a) : 32'(r0_num_a);
        w_mag_b = r0_num_b[31] ? 32'(-r0_num_b) : 32'(r0_num_b);
        w_v_a   = {w_mag_a[27:0], 4'b0} + 32'(w_s1.off);
        w_v_b   = {w_mag_b[27:0], 4'b0} + 32'(w_s1.off);
        w_pa    = w_v_a * w_s1.recip;
        w_pb    = w_v_b * w_s1.recip;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_lg    <= w_lg;
            r1_q_a   <= w_pa[50:32];
            r1_q_b   <= w_pb[50:32];
            r1_v_a   <= w_v_a;
            r1_v_b   <= w_v_b;
            r1_neg_a <= r0_num_a[31];
            r1_neg_b <= r0_num_b[31];
            r1_upper <= r0_upper;
            r1_known <= r0_known;
        end
    end

    // stage 2: quotient correction, sign restore
    t_seg        w_s2;
    logic [34:0] w_qc_a, w_qc_b, w_r_a, w_r_b;
    logic [19:0] w_qa, w_qb;

    always_comb begin
        w_s2   = f_seg(r_sensor_model, r1_upper);
        w_qc_a = r1_q_a * w_s2.div;
        w_qc_b = r1_q_b * w_s2.div;
        w_r_a  = {3'b0, r1_v_a} - w_qc_a;
        w_r_b  = {3'b0, r1_v_b} - w_qc_b;
        w_qa   = {1'b0, r1_q_a} + 20'(w_r_a >= 35'(w_s2.div));
        w_qb   = {1'b0, r1_q_b} + 20'(w_r_b >= 35'(w_s2.div));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_lg    <= r1_lg;
            r2_a     <= r1_neg_a ? -$signed(w_qa) : $signed(w_qa);
            r2_b     <= r1_neg_b ? -$signed(w_qb) : $signed(w_qb);
            r2_known <= r1_known;
        end
    end

    // stage 3: b * log2(t)
    logic signed [39:0] w_py;

    assign w_py = r2_b * $signed({2'b0, r2_lg});

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_py    <= w_py;
            r3_a     <= r2_a;
            r3_known <= r2_known;
        end
    end

    // stage 4: round to Q16, clamp to +-8, exp2 of the fraction
    logic [39:0]        w_mag_y;
    logic [39:0]        w_rnd_y;
    logic signed [24:0] w_y;
    logic signed [19:0] w_yc;
    logic [31:0]        w_ef;

    always_comb begin
        w_mag_y = r3_py[39] ? 40'(-r3_py) : 40'(r3_py);
        w_rnd_y = w_mag_y + 40'd32768;
        w_y     = r3_py[39] ? -$signed({1'b0, w_rnd_y[39:16]})
                            : $signed({1'b0, w_rnd_y[39:16]});
        if (w_y < -25'sd524288) begin
            w_yc = -20'sd524288;
        end else if (w_y > 25'sd524287) begin
            w_yc = 20'sd524287;
        end else begin
            w_yc = w_y[19:0];
        end
    end

    gsec_exp2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_exp2 (
        .i_frac (w_yc[15:0]),
        .o_ef   (w_ef)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_ef    <= w_ef;
            r4_ip    <= w_yc[19:16];
            r4_a     <= r3_a;
            r4_known <= r3_known;
        end
    end

    // stage 5: a * exp2
    logic [50:0] w_prod;

    assign w_prod = r4_a[18:0] * r4_ef;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_prod   <= w_prod;
            r5_ip     <= r4_ip;
            r5_nonpos <= r4_a[19] || (r4_a == '0);
            r5_known  <= r4_known;
        end
    end

    // stage 6: scale by 2^ip, round, saturate; unit for unknown model, zero for a <= 0
    logic signed [7:0] w_sh;
    logic [51:0]       w_sum, w_res;
    logic [15:0]       w_corr;

    always_comb begin
        w_sh  = 8'(SH_BASE) - 8'(r5_ip);
        w_sum = {1'b0, r5_prod} + (52'd1 << (w_sh[5:0] - 6'd1));
        w_res = w_sum >> w_sh[5:0];
        if (!r5_known) begin
            w_corr = UNIT_OUT;
        end else if (r5_nonpos) begin
            w_corr = '0;
        end else if (|w_res[51:16]) begin
            w_corr = 16'hFFFF;
        end else begin
            w_corr = w_res[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_corr <= w_corr;
        end
    end

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while pipeline full and stalled");

    a_unknown_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !w_known) |-> (o_out.correction == UNIT_OUT))
        else $error("unknown model did not give unit correction");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted transaction lost at first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

>>> verif/gas_sensor_env_compensation_tb.sv
`timescale 1ns / 1ps
// Testbench for gas_sensor_env_compensation: directed table, then random readings per model,
// all checked in order against table values or a bit-accurate correction predictor.
// Depends on gsec_pkg, gsec_in_if, gsec_out_if and the block itself.
module gas_sensor_env_compensation_tb;
    import gsec_pkg::*;

    localparam int FRAC_BITS = 14;
    localparam int TAB_BITS  = 6;
    localparam int TAB_SIZE  = 1 << TAB_BITS;

    typedef struct {
        logic [3:0]         model;
        logic signed [15:0] temp;
        logic [14:0]        hum;
        bit                 known;
        logic [15:0]        value;
    } reading_t;

    typedef struct {
        longint lo, hi, a0, a1, b0, b1;
    } fit_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [3:0] i_cfg_wdata;

    gsec_in_if  in_ch ();
    gsec_out_if out_ch ();

    gas_sensor_env_compensation #(
        .OUT_FRAC_BITS (FRAC_BITS),
        .LOG_TABLE_BITS(TAB_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    longint unsigned log_lut [TAB_SIZE + 1];
    longint unsigned exp_lut [TAB_SIZE + 1];
    logic [15:0] pending_corrections [$];
    logic [3:0]  cur_model;
    int          mismatches;
    longint      cycle_cnt;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v, r, b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void build_luts();
        longint unsigned root [TAB_BITS + 1];
        longint unsigned x, acc, v;
        root[0] = 64'd1 << 31;
        for (int i = 1; i <= TAB_BITS; i++) root[i] = int_sqrt(root[i - 1] << 30);
        for (int k = 0; k < TAB_SIZE; k++) begin
            x = (64'd1 << 30) + (longint'(k) << (30 - TAB_BITS));
            acc = 0;
            v = 64'd1 << 30;
            for (int i = 1; i <= 16; i++) begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31)) begin
                    x = x >> 1;
                    acc = acc | (64'd1 << (16 - i));
                end
            end
            log_lut[k] = acc;
            for (int i = 1; i <= TAB_BITS; i++)
                if (((k >> (TAB_BITS - i)) & 1) != 0) v = (v * root[i]) >> 30;
            exp_lut[k] = v;
        end
        log_lut[TAB_SIZE] = 64'd1 << 16;
        exp_lut[TAB_SIZE] = 64'd1 << 31;
    endfunction

    function automatic longint round_div(input longint n, input longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic fit_t pick_fit(input logic [3:0] m, input bit upper);
        fit_t f;
        f.lo = 33; f.hi = 85;
        case (m)
            MODEL_GROUP: begin f.a0 = 16867; f.a1 = 15291; f.b0 = -4263; f.b1 = -4220; end
            MODEL_S2:    begin f.a0 = 12767; f.a1 = 11013; f.b0 = -2204; f.b1 = -2482; end
            MODEL_S3:    begin f.a0 = 13645; f.a1 = 11315; f.b0 = -2977; f.b1 = -2874; end
            MODEL_S4:    begin f.a0 = 13128; f.a1 = 11252; f.b0 = -2428; f.b1 = -2496; end
            MODEL_S5:    begin f.a0 = 14296; f.a1 = 11733; f.b0 = -3238; f.b1 = -2842; end
            MODEL_S6:    begin f.a0 = 11474; f.a1 = 10783; f.b0 = -1958; f.b1 = -1824; end
            MODEL_S7:    begin f.a0 = 14292; f.a1 = 11735; f.b0 = -3206; f.b1 = -2801; end
            MODEL_ALC:   begin f.a0 = 16671; f.a1 = 14112; f.b0 = -2467; f.b1 = -2257; end
            default: begin
                if (upper) begin
                    f.lo = 60; f.hi = 85;
                    f.a0 = 15885; f.a1 = 13842; f.b0 = -2271; f.b1 = -2282;
                end else begin
                    f.lo = 30; f.hi = 60;
                    f.a0 = 18760; f.a1 = 15885; f.b0 = -2284; f.b1 = -2271;
                end
            end
        endcase
        return f;
    endfunction

    function automatic logic [15:0] correction_factor(input logic [3:0] m,
                                                      input logic signed [15:0] temp,
                                                      input logic [14:0] hum);
        longint tc, h, a, b, y, lo, hi, hlo, split, num;
        longint unsigned t, lg, m30, frac, idx, rem, u, fr, ef, prod, res;
        int p, ip, sh;
        bit tmap2;
        fit_t f;
        if (m < MODEL_FIRST || m > MODEL_LAST) return 16'(1 << FRAC_BITS);
        tmap2 = (m == MODEL_ALC || m == MODEL_OZONE);
        hlo   = (m == MODEL_OZONE) ? 33 : 30;
        split = (m == MODEL_OZONE) ? 60 : 85;
        tc = temp;
        if (tc < -2560) tc = -2560;
        if (tc > 12800) tc = 12800;
        if (!tmap2) t = ((tc + 6400) * 65536 + 1920) / 3840;
        else        t = ((tc + 3840) * 65536 + 640) / 1280;
        h = hum;
        if (h < hlo * 256) h = hlo * 256;
        if (h > 85 * 256) h = 85 * 256;
        f = pick_fit(m, h > split * 256);
        lo = f.lo * 256;
        hi = f.hi * 256;
        num = f.a0 * (hi - h) + f.a1 * (h - lo);
        a = round_div(num * 65536, (hi - lo) * 10000);
        num = f.b0 * (hi - h) + f.b1 * (h - lo);
        b = round_div(num * 65536, (hi - lo) * 10000);
        p = 19;
        while (p > 16 && ((t >> p) & 1) == 0) p--;
        m30  = t << (30 - p);
        frac = m30 - (64'd1 << 30);
        idx  = frac >> (30 - TAB_BITS);
        rem  = frac & ((64'd1 << (30 - TAB_BITS)) - 1);
        lg = (longint'(p - 16) << 16) + log_lut[idx]
           + (((log_lut[idx + 1] - log_lut[idx]) * rem) >> (30 - TAB_BITS));
        y = round_div(b * longint'(lg), 65536);
        if (y < -8 * 65536) y = -8 * 65536;
        if (y > 8 * 65536 - 1) y = 8 * 65536 - 1;
        u   = y + 8 * 65536;
        ip  = int'(u >> 16) - 8;
        fr  = u & 16'hFFFF;
        idx = fr >> (16 - TAB_BITS);
        rem = fr & ((64'd1 << (16 - TAB_BITS)) - 1);
        ef  = exp_lut[idx] + (((exp_lut[idx + 1] - exp_lut[idx]) * rem) >> (16 - TAB_BITS));
        if (a <= 0) return 16'd0;
        prod = longint'(a) * ef;
        sh   = 46 - FRAC_BITS - ip;
        res  = (prod + (64'd1 << (sh - 1))) >> sh;
        return (res > 65535) ? 16'hFFFF : res[15:0];
    endfunction

    // Receiver stall pattern: cycles through always ready, mostly ready, half ready and a sparse periodic pattern.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        case ((cycle_cnt >> 6) % 4)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= ($urandom_range(0, 1) != 0);
            default: out_ch.ready <= ((cycle_cnt % 9) < 2);
        endcase
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_corrections.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected correction %0d", $realtime, out_ch.correction);
            end else begin
                want = pending_corrections.pop_front();
                if (out_ch.correction !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: correction expected %0d got %0d", $realtime, want,
                                 out_ch.correction);
                end
            end
        end
    end

    int burst_left;

    task automatic send_reading(input logic signed [15:0] temp, input logic [14:0] hum,
                                input bit known, input logic [15:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.temperature <= temp;
        in_ch.humidity    <= hum;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_corrections.push_back(known ? value : correction_factor(cur_model, temp, hum));
    endtask

    task automatic write_model(input logic [3:0] m);
        in_ch.valid <= 1'b0;
        while (pending_corrections.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_model = m;
    endtask

    reading_t directed [] = '{
        '{MODEL_NONE,  16'sh8000, 15'd0,     1'b1, 16'd16384},
        '{MODEL_NONE,  16'sh7FFF, 15'h7FFF,  1'b1, 16'd16384},
        '{MODEL_GROUP, 16'sh8000, 15'd0,     1'b0, 16'd0},
        '{MODEL_GROUP, 16'sh7FFF, 15'h7FFF,  1'b0, 16'd0},
        '{MODEL_GROUP, -16'sd2560, 15'd7680, 1'b0, 16'd0},
        '{MODEL_GROUP, 16'sd12800, 15'd25600, 1'b0, 16'd0},
        '{MODEL_GROUP, 16'sd5120, 15'd8448,  1'b0, 16'd0},
        '{MODEL_S2,    16'sd0,    15'd12800, 1'b0, 16'd0},
        '{MODEL_S3,    16'sd2560, 15'd21760, 1'b0, 16'd0},
        '{MODEL_S4,    -16'sd2561, 15'd21761, 1'b0, 16'd0},
        '{MODEL_S5,    16'sd12801, 15'd100,  1'b0, 16'd0},
        '{MODEL_S6,    16'sd7000, 15'd15000, 1'b0, 16'd0},
        '{MODEL_S7,    -16'sd1000, 15'd20000, 1'b0, 16'd0},
        '{MODEL_ALC,   -16'sd2560, 15'd0,    1'b0, 16'd0},
        '{MODEL_ALC,   16'sd12800, 15'h7FFF, 1'b0, 16'd0},
        '{MODEL_OZONE, -16'sd2560, 15'd8447, 1'b0, 16'd0},
        '{MODEL_OZONE, 16'sd3000, 15'd15360, 1'b0, 16'd0},
        '{MODEL_OZONE, 16'sd3000, 15'd15361, 1'b0, 16'd0},
        '{MODEL_OZONE, 16'sd12800, 15'd25600, 1'b0, 16'd0},
        '{MODEL_OZONE, 16'sh8000, 15'h7FFF,  1'b0, 16'd0},
        '{4'd10,       16'sd100,  15'd100,   1'b1, 16'd16384},
        '{4'd15,       16'sh7FFF, 15'h7FFF,  1'b1, 16'd16384}
    };

    initial begin
        logic [3:0] plan [] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
                                4'd0, 4'd15, 4'd9, 4'd1, 4'd12, 4'd8, 4'd9};
        logic signed [15:0] temp;
        logic [14:0] hum;
        build_luts();
        mismatches  = 0;
        cycle_cnt   = 0;
        burst_left  = 0;
        cur_model   = MODEL_NONE;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 4'd0;
        in_ch.valid = 1'b0;
        in_ch.temperature = '0;
        in_ch.humidity    = '0;
        out_ch.ready      = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].model != cur_model) write_model(directed[i].model);
            send_reading(directed[i].temp, directed[i].hum, directed[i].known,
                         directed[i].value);
        end

        foreach (plan[ph]) begin
            write_model(plan[ph]);
            repeat (50) begin
                if ($urandom_range(0, 3) != 0) temp = 16'($urandom_range(0, 15600)) - 16'sd2700;
                else temp = 16'($urandom);
                if ($urandom_range(0, 4) != 0) hum = 15'($urandom_range(0, 25600));
                else hum = 15'($urandom);
                send_reading(temp, hum, 1'b0, 16'd0);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_corrections.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hdl/gsec_pkg.sv
hdl/gsec_in_if.sv
hdl/gsec_out_if.sv
hdl/gsec_log2.sv
hdl/gsec_exp2.sv
hdl/gas_sensor_env_compensation.sv
verif/gas_sensor_env_compensation_tb.sv
